>>> sv/mic_pkg.sv
// Shared types, constants and coefficient functions for the magnetometer iron correction.
package mic_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 18;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_X   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_Y   = 2'd3;

  localparam int OFFSET_WIDTH   = 18;
  localparam int GAIN_WIDTH     = 17;
  localparam int GAIN_FRAC_BITS = 16;

  localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_X_RESET = 18'sd27680;
  localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_Y_RESET = -18'sd5280;
  localparam logic [GAIN_WIDTH-1:0]          GAIN_X_RESET   = 17'd61456;
  localparam logic [GAIN_WIDTH-1:0]          GAIN_Y_RESET   = 17'd70197;

  // Decimal coefficients, scaled by 1e8.
  localparam longint E8_SCALE = 100000000;
  localparam longint TILT_E8 [3][3] = '{
    '{100000000, 0, 703476},
    '{0, 100000000, -7186357},
    '{-698555, 7744466, 100000000}
  };
  localparam longint ROT_E8 [3][3] = '{
    '{-74874188, 66286168, 0},
    '{-66286168, -74874188, 0},
    '{0, 0, 100000000}
  };

  typedef enum logic [1:0] {
    MAT_TILT,
    MAT_ROT,
    MAT_ROT_T
  } mat_sel_t;

  // Clock enables of the two register stages inside one matrix unit.
  typedef struct packed {
    logic prod;
    logic sum;
  } mic_stage_en_t;

  function automatic longint mat_e8(mat_sel_t sel, int r, int c);
    longint v;
    v = 0;
    unique case (sel)
      MAT_TILT:  v = TILT_E8[r][c];
      MAT_ROT:   v = ROT_E8[r][c];
      MAT_ROT_T: v = ROT_E8[c][r];
      default:   v = 0;
    endcase
    return v;
  endfunction

  // Rounds to nearest with halves away from zero.
  function automatic longint coef_q(longint e8, int frac);
    longint mag;
    longint q;
    mag = (e8 < 0) ? -e8 : e8;
    q = (mag * (longint'(1) << frac) + (E8_SCALE / 2)) / E8_SCALE;
    return (e8 < 0) ? -q : q;
  endfunction

endpackage

>>> sv/mic_matvec.sv
// Constant 3x3 matrix times vector: registered products, then registered rounded sums.
module mic_matvec
  import mic_pkg::*;
#(
  parameter mat_sel_t MAT  = MAT_TILT,
  parameter int       IN_W  = 21,
  parameter int       OUT_W = 22,
  parameter int       FRAC  = 16
) (
  input  logic                    clk,
  input  mic_stage_en_t           en,
  input  logic signed [IN_W-1:0]  din  [3],
  output logic signed [OUT_W-1:0] dout [3]
);

  localparam int     CW   = FRAC + 2;
  localparam int     PW   = IN_W + CW;
  localparam int     SW   = PW + 2;
  localparam longint HALF = longint'(1) << (FRAC - 1);

  logic signed [PW-1:0] prod [3][3];
  logic signed [SW-1:0] sum  [3];
  logic signed [SW-1:0] rnd  [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam logic signed [CW-1:0] K = CW'(coef_q(mat_e8(MAT, r, c), FRAC));
      always_ff @(posedge clk) begin
        if (en.prod) begin
          prod[r][c] <= PW'(din[c]) * PW'(K);
        end
      end
    end

    // Adding one half before the arithmetic shift rounds halves upward.
    always_comb begin
      sum[r] = SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2]) + SW'(HALF);
      rnd[r] = sum[r] >>> FRAC;
    end

    always_ff @(posedge clk) begin
      if (en.sum) begin
        dout[r] <= rnd[r][OUT_W-1:0];
      end
    end
  end

endmodule

>>> sv/magnetometer_iron_correction.sv
// Top level of the magnetometer hard- and soft-iron correction pipeline.
//
// One three-axis field sample (field_x, field_y, field_z, in nanotesla) is
// taken on every transfer of the input channel (in_valid high, in_stall low).
// The corrected sample and its clipped flag appear on the output channel,
// transferred when out_valid is high and out_stall is low.
// The datapath is nine register stages: tilt matrix products and sums, soft-iron
// rotation products and sums, gain products and rounding, back-rotation products
// and sums, and the offset add with saturation into the output register.
// out_valid rises once the sample reaches the output register; one sample can be
// taken every cycle, limited only by the output side.
// When the receiver stalls, the result holds in the output register while
// earlier stages keep moving until every stage holds a sample; only then does
// in_stall rise. No sample is lost or repeated.
// Reset clears all stage valid bits and loads the default offsets and gains.
// Registers are written through cfg_we, cfg_index and cfg_data, and should be
// changed only while no sample is in flight.
module magnetometer_iron_correction
  import mic_pkg::*;
#(
  parameter int FIELD_WIDTH    = 21,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [FIELD_WIDTH-1:0]     field_x,
  input  logic signed [FIELD_WIDTH-1:0]     field_y,
  input  logic signed [FIELD_WIDTH-1:0]     field_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [FIELD_WIDTH-1:0]     corrected_x,
  output logic signed [FIELD_WIDTH-1:0]     corrected_y,
  output logic signed [FIELD_WIDTH-1:0]     corrected_z,
  output logic                              clipped
);

  localparam int W      = FIELD_WIDTH;
  localparam int STAGES = 9;
  localparam int GPW    = W + 1 + GAIN_WIDTH + 1;
  localparam int FW     = W + 4;
  localparam longint GHALF = longint'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [FW-1:0] SAT_HI = FW'((longint'(1) << (W - 1)) - 1);
  localparam logic signed [FW-1:0] SAT_LO = FW'(-(longint'(1) << (W - 1)));

  // Configuration registers.
  logic signed [OFFSET_WIDTH-1:0] offset_x;
  logic signed [OFFSET_WIDTH-1:0] offset_y;
  logic [GAIN_WIDTH-1:0]          gain_x;
  logic [GAIN_WIDTH-1:0]          gain_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= OFFSET_X_RESET;
      offset_y <= OFFSET_Y_RESET;
      gain_x   <= GAIN_X_RESET;
      gain_y   <= GAIN_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_GAIN_X:   gain_x   <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_Y:   gain_y   <= cfg_data[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and enables. A stage loads when it is empty or when the
  // stage after it loads, so bubbles collapse while the output is stalled.
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[STAGES-1];

  // Tilt matrix.
  logic signed [W-1:0] raw  [3];
  logic signed [W:0]   flat [3];

  assign raw[0] = field_x;
  assign raw[1] = field_y;
  assign raw[2] = field_z;

  mic_matvec #(
    .MAT(MAT_TILT), .IN_W(W), .OUT_W(W + 1), .FRAC(COEF_FRAC_BITS)
  ) u_tilt (
    .clk(clk), .en('{prod: en[0], sum: en[1]}), .din(raw), .dout(flat)
  );

  // Rotation into the soft-iron axes.
  logic signed [W:0] si [3];

  mic_matvec #(
    .MAT(MAT_ROT), .IN_W(W + 1), .OUT_W(W + 1), .FRAC(COEF_FRAC_BITS)
  ) u_rot (
    .clk(clk), .en('{prod: en[2], sum: en[3]}), .din(flat), .dout(si)
  );

  // Soft-iron gains on x and y; z rides along.
  logic signed [GPW-1:0] gprod_x;
  logic signed [GPW-1:0] gprod_y;
  logic signed [W:0]     gz;
  logic signed [GPW-1:0] gsum_x;
  logic signed [GPW-1:0] gsum_y;
  logic signed [GPW-1:0] grnd_x;
  logic signed [GPW-1:0] grnd_y;
  logic signed [W+1:0]   sg [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      gprod_x <= GPW'(si[0]) * GPW'($signed({1'b0, gain_x}));
      gprod_y <= GPW'(si[1]) * GPW'($signed({1'b0, gain_y}));
      gz      <= si[2];
    end
  end

  always_comb begin
    gsum_x = gprod_x + GPW'(GHALF);
    gsum_y = gprod_y + GPW'(GHALF);
    grnd_x = gsum_x >>> GAIN_FRAC_BITS;
    grnd_y = gsum_y >>> GAIN_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sg[0] <= grnd_x[W+1:0];
      sg[1] <= grnd_y[W+1:0];
      sg[2] <= (W + 2)'(gz);
    end
  end

  // Back-rotation by the transposed matrix.
  logic signed [W+2:0] res [3];

  mic_matvec #(
    .MAT(MAT_ROT_T), .IN_W(W + 2), .OUT_W(W + 3), .FRAC(COEF_FRAC_BITS)
  ) u_rot_t (
    .clk(clk), .en('{prod: en[6], sum: en[7]}), .din(sg), .dout(res)
  );

  // Hard-iron offsets and saturation.
  logic signed [FW-1:0]  fin [3];
  logic signed [W-1:0]   sat [3];
  logic [2:0]            clip_axis;

  always_comb begin
    fin[0] = FW'(res[0]) + FW'(offset_x);
    fin[1] = FW'(res[1]) + FW'(offset_y);
    fin[2] = FW'(res[2]);
    for (int i = 0; i < 3; i++) begin
      clip_axis[i] = 1'b0;
      sat[i] = fin[i][W-1:0];
      if (fin[i] > SAT_HI) begin
        sat[i] = SAT_HI[W-1:0];
        clip_axis[i] = 1'b1;
      end else if (fin[i] < SAT_LO) begin
        sat[i] = SAT_LO[W-1:0];
        clip_axis[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      corrected_x <= sat[0];
      corrected_y <= sat[1];
      corrected_z <= sat[2];
      clipped     <= |clip_axis;
    end
  end

  // The input side only stalls when every stage holds a sample.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld && out_stall))
    else $error("input stalled while the pipeline had an empty stage");

  // An input transfer always lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted sample not captured in the first stage");

  // A clipped result sits on a range limit on at least one axis.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (corrected_x == SAT_HI[W-1:0] || corrected_x == SAT_LO[W-1:0] ||
       corrected_y == SAT_HI[W-1:0] || corrected_y == SAT_LO[W-1:0] ||
       corrected_z == SAT_HI[W-1:0] || corrected_z == SAT_LO[W-1:0]))
    else $error("clipped flag set without a saturated axis");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the magnetometer hard- and soft-iron correction pipeline.
`timescale 1ns / 100ps

module tb;
  import mic_pkg::*;

  localparam int FW        = 21;
  localparam int COEF_FRAC = 16;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 20;
  localparam int BLOCK_ITEMS  = 50;

  // Matrix coefficients as round(c * 2^16), halves away from zero.
  localparam longint Q_ONE = 65536;
  localparam longint Q_T02 = 461;
  localparam longint Q_T12 = -4710;
  localparam longint Q_T20 = -458;
  localparam longint Q_T21 = 5075;
  localparam longint Q_RA  = -49070;
  localparam longint Q_RB  = 43441;

  typedef logic signed [FW-1:0] field_t;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t z;
    logic   clip;
  } sample_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_PREDICT,
    ROW_KNOWN
  } row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    field_t                    x;
    field_t                    y;
    field_t                    z;
    logic [CFG_DATA_WIDTH-1:0] ox;
    logic [CFG_DATA_WIDTH-1:0] oy;
    logic [CFG_DATA_WIDTH-1:0] gx;
    logic [CFG_DATA_WIDTH-1:0] gy;
    sample_t                   known;
  } row_t;

  localparam field_t FIELD_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam field_t FIELD_MIN = {1'b1, {(FW-1){1'b0}}};

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  field_t                     field_x;
  field_t                     field_y;
  field_t                     field_z;
  logic                       out_valid;
  logic                       out_stall;
  field_t                     corrected_x;
  field_t                     corrected_y;
  field_t                     corrected_z;
  logic                       clipped;

  // Mirror of the calibration registers.
  logic signed [OFFSET_WIDTH-1:0] cal_offset_x;
  logic signed [OFFSET_WIDTH-1:0] cal_offset_y;
  logic [GAIN_WIDTH-1:0]          cal_gain_x;
  logic [GAIN_WIDTH-1:0]          cal_gain_y;

  sample_t pending_corrections[$];
  row_t    directed_rows[$];

  int mismatches     = 0;
  int samples_sent   = 0;
  int settings_count = 0;
  int saturated_seen = 0;
  int input_held     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;

  magnetometer_iron_correction #(
    .FIELD_WIDTH   (FW),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .field_x    (field_x),
    .field_y    (field_y),
    .field_z    (field_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .corrected_x(corrected_x),
    .corrected_y(corrected_y),
    .corrected_z(corrected_z),
    .clipped    (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Round to nearest, halves toward plus infinity.
  function automatic longint round_q16(longint v);
    return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic field_t saturate(longint v, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (FW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return FIELD_MAX;
    end
    if (v < lo) begin
      hit = 1'b1;
      return FIELD_MIN;
    end
    return field_t'(v);
  endfunction

  function automatic sample_t correct_field(field_t fx, field_t fy, field_t fz);
    longint  x, y, z;
    longint  t0, t1, t2;
    longint  s0, s1, s2;
    longint  b0, b1;
    sample_t o;
    logic    hit;
    x = fx;
    y = fy;
    z = fz;
    t0 = round_q16(Q_ONE * x + Q_T02 * z);
    t1 = round_q16(Q_ONE * y + Q_T12 * z);
    t2 = round_q16(Q_T20 * x + Q_T21 * y + Q_ONE * z);
    s0 = round_q16(Q_RA * t0 + Q_RB * t1);
    s1 = round_q16(-Q_RB * t0 + Q_RA * t1);
    s2 = round_q16(Q_ONE * t2);
    b0 = round_q16(s0 * longint'(cal_gain_x));
    b1 = round_q16(s1 * longint'(cal_gain_y));
    hit = 1'b0;
    // The back-rotation uses the transpose, so the sign of b moves.
    o.x = saturate(round_q16(Q_RA * b0 - Q_RB * b1) + longint'(cal_offset_x), hit);
    o.y = saturate(round_q16(Q_RB * b0 + Q_RA * b1) + longint'(cal_offset_y), hit);
    o.z = saturate(round_q16(Q_ONE * s2), hit);
    o.clip = hit;
    return o;
  endfunction

  function automatic void add_load(int ox, int oy, int gx, int gy);
    row_t r;
    r = '{kind: ROW_LOAD, default: '0};
    r.ox = 18'(ox);
    r.oy = 18'(oy);
    r.gx = 18'(gx);
    r.gy = 18'(gy);
    directed_rows.push_back(r);
  endfunction

  function automatic void add_sample(int x, int y, int z);
    row_t r;
    r = '{kind: ROW_PREDICT, default: '0};
    r.x = field_t'(x);
    r.y = field_t'(y);
    r.z = field_t'(z);
    directed_rows.push_back(r);
  endfunction

  function automatic void add_known(int x, int y, int z, int ex, int ey, int ez);
    row_t r;
    r = '{kind: ROW_KNOWN, default: '0};
    r.x = field_t'(x);
    r.y = field_t'(y);
    r.z = field_t'(z);
    r.known = {field_t'(ex), field_t'(ey), field_t'(ez), 1'b0};
    directed_rows.push_back(r);
  endfunction

  function automatic field_t pick_field();
    case ($urandom_range(0, 9))
      0:       return FIELD_MAX;
      1:       return FIELD_MIN;
      2:       return field_t'(int'($urandom_range(0, 64)) - 32);
      default: return field_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_gain_word();
    logic [CFG_DATA_WIDTH-1:0] w;
    w = 18'($urandom);
    case ($urandom_range(0, 7))
      0:       w[GAIN_WIDTH-1:0] = '0;
      1:       w[GAIN_WIDTH-1:0] = '1;
      2, 3:    w[GAIN_WIDTH-1:0] = 17'(32'd65536 + $urandom_range(0, 16384) - 32'd8192);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_offset_word();
    case ($urandom_range(0, 7))
      0:       return 18'h1FFFF;
      1:       return 18'h20000;
      2:       return 18'(int'($urandom_range(0, 60000)) - 30000);
      default: return 18'($urandom);
    endcase
  endfunction

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_OFFSET_X: cal_offset_x = data[OFFSET_WIDTH-1:0];
      REG_OFFSET_Y: cal_offset_y = data[OFFSET_WIDTH-1:0];
      REG_GAIN_X:   cal_gain_x   = data[GAIN_WIDTH-1:0];
      REG_GAIN_Y:   cal_gain_y   = data[GAIN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_WIDTH-1:0] ox,
                               input logic [CFG_DATA_WIDTH-1:0] oy,
                               input logic [CFG_DATA_WIDTH-1:0] gx,
                               input logic [CFG_DATA_WIDTH-1:0] gy);
    wait_drained();
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // in_valid stays high across back-to-back transfers; it only drops in an idle gap or while draining.
  task automatic send_sample(input field_t x, input field_t y, input field_t z,
                             input bit has_known, input sample_t known);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    field_x  <= x;
    field_y  <= y;
    field_z  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has_known) pending_corrections.push_back(known);
    else pending_corrections.push_back(correct_field(x, y, z));
    samples_sent++;
  endtask

  task automatic random_block(int count);
    load_settings(pick_offset_word(), pick_offset_word(), pick_gain_word(), pick_gain_word());
    repeat (count) send_sample(pick_field(), pick_field(), pick_field(), 1'b0, '0);
  endtask

  // Receiver side: random stall, plus one long hold-off on request.
  initial begin : sink_driver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin : result_check
    sample_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (clipped) saturated_seen++;
        if (pending_corrections.size() == 0) begin
          $error("unexpected transfer: %0d %0d %0d clipped %0b",
                 corrected_x, corrected_y, corrected_z, clipped);
          mismatches++;
        end else begin
          want = pending_corrections.pop_front();
          if (corrected_x !== want.x) begin
            $error("corrected_x expected %0d actual %0d", want.x, corrected_x);
            mismatches++;
          end
          if (corrected_y !== want.y) begin
            $error("corrected_y expected %0d actual %0d", want.y, corrected_y);
            mismatches++;
          end
          if (corrected_z !== want.z) begin
            $error("corrected_z expected %0d actual %0d", want.z, corrected_z);
            mismatches++;
          end
          if (clipped !== want.clip) begin
            $error("clipped expected %0b actual %0b", want.clip, clipped);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_valid && in_stall) input_held++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    row_t row;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    field_x   <= '0;
    field_y   <= '0;
    field_z   <= '0;
    cal_offset_x = OFFSET_X_RESET;
    cal_offset_y = OFFSET_Y_RESET;
    cal_gain_x   = GAIN_X_RESET;
    cal_gain_y   = GAIN_Y_RESET;

    // Reset settings.
    add_known(0, 0, 0, 27680, -5280, 0);
    add_sample(int'(FIELD_MAX), int'(FIELD_MAX), int'(FIELD_MAX));
    add_sample(int'(FIELD_MIN), int'(FIELD_MIN), int'(FIELD_MIN));
    add_sample(int'(FIELD_MAX), int'(FIELD_MIN), 0);
    add_sample(int'(FIELD_MIN), int'(FIELD_MAX), int'(FIELD_MAX));
    add_sample(1, -1, 1);
    // Zero gains with extreme offsets; bit 17 of the gain words must be dropped.
    add_load('h1FFFF, 'h20000, 'h20000, 'h00000);
    add_known(0, 0, 0, 131071, -131072, 0);
    add_known(0, 0, int'(FIELD_MAX), 131071, -131072, int'(FIELD_MAX));
    add_known(0, 0, int'(FIELD_MIN), 131071, -131072, int'(FIELD_MIN));
    add_sample(int'(FIELD_MAX), int'(FIELD_MIN), int'(FIELD_MAX));
    // Largest gains drive x and y past the field range.
    add_load('h20000, 'h1FFFF, 'h3FFFF, 'h3FFFF);
    add_sample(int'(FIELD_MAX), 0, 0);
    add_sample(int'(FIELD_MIN), 0, 0);
    add_sample(0, int'(FIELD_MAX), 0);
    add_sample(0, int'(FIELD_MIN), 0);
    add_sample(int'(FIELD_MAX), int'(FIELD_MAX), int'(FIELD_MIN));
    add_sample(int'(FIELD_MIN), int'(FIELD_MIN), int'(FIELD_MAX));
    // Unity gains, no offsets.
    add_load(0, 0, 'h10000, 'h10000);
    add_known(0, 0, 0, 0, 0, 0);
    add_sample(12345, -54321, 777);
    add_sample(-1, -1, -1);
    add_sample(int'(FIELD_MAX), int'(FIELD_MAX), int'(FIELD_MAX));
    add_sample(int'(FIELD_MIN), int'(FIELD_MIN), int'(FIELD_MIN));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 15;
    recv_stall_pct = 58;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_LOAD) load_settings(row.ox, row.oy, row.gx, row.gy);
      else send_sample(row.x, row.y, row.z, row.kind == ROW_KNOWN, row.known);
    end

    repeat (3) random_block(BLOCK_ITEMS);

    send_idle_pct  = 58;
    recv_stall_pct = 15;
    repeat (3) random_block(BLOCK_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_settings(pick_offset_word(), pick_offset_word(), pick_gain_word(), pick_gain_word());
    // The receiver holds off while samples keep coming, so the pipeline fills.
    hold_request = 1'b1;
    repeat (BLOCK_ITEMS) send_sample(pick_field(), pick_field(), pick_field(), 1'b0, '0);
    repeat (2) random_block(BLOCK_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d samples over %0d register settings, three idle patterns",
             samples_sent, settings_count);
    $display("summary: %0d saturated results, input stalled for %0d cycles",
             saturated_seen, input_held);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> magnetometer_iron_correction.f
sv/mic_pkg.sv
sv/mic_matvec.sv
sv/magnetometer_iron_correction.sv
tb/tb.sv
